// ===== hw/rtl/tmh_pkg.sv =====
// tmh_pkg: shared types and constants of the timer min-heap
// holds payload structs, heap entry, cell-to-cell transfer structs and fsm states
// no dependencies
package tmh_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W = 32;
	localparam int ID_W = 16;
	localparam int OCC_W = 7;
	// widths cover the largest supported capacity of 4096 entries
	localparam int CNT_W = 13;
	localparam int LVL_W = 4;
	localparam int OFF_W = 12;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_TICK = 2'd1,
		CMD_POP  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_REMOVED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NONE_DUE = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [ID_W-1:0]  timer_id;
		logic [KEY_W-1:0] expire_time;
		logic [KEY_W-1:0] now_time;
	} in_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  out_id;
		logic [KEY_W-1:0] out_expire;
		logic [OCC_W-1:0] occupancy;
		logic             last;
	} out_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef enum logic {
		W_ADD  = 1'b0,
		W_SIFT = 1'b1
	} wave_op_t;

	// operation travelling down the levels
	typedef struct packed {
		logic             vld;
		wave_op_t         op;
		logic [LVL_W-1:0] tgt;
		logic [CNT_W-1:0] path;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] size;
		logic             disp;
		entry_t           ent;
	} wave_t;

	// write into the level above
	typedef struct packed {
		logic             vld;
		logic [OFF_W-1:0] off;
		entry_t           ent;
	} wr_t;

	// side read of one entry
	typedef struct packed {
		logic             vld;
		logic [LVL_W-1:0] lvl;
		logic [OFF_W-1:0] off;
	} prb_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_TAKE,
		S_POP_LOAD,
		S_RUN,
		S_EMIT
	} state_t;

endpackage

// ===== hw/rtl/tmh_cell.sv =====
// tmh_cell: one heap level, entries kept as sibling pairs in two banks
// compares and moves entries for add and sift-down, hands the transfer to the next level
// depends on tmh_pkg
module tmh_cell import tmh_pkg::*; #(
	parameter int LVL = 1,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  wave_t  wave_in,
	output wave_t  wave_out,
	input  wr_t    wr_in,
	output wr_t    wr_out,
	input  prb_t   prb,
	output entry_t prb_ent,
	output logic   done
);

	localparam int FULL_LVL = 1 << LVL;
	localparam int REST = DEPTH + 1 - FULL_LVL;
	localparam int CAP = (FULL_LVL < REST) ? FULL_LVL : REST;
	localparam int BD = (CAP + 1) / 2;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;
	localparam logic [CNT_W:0] BASE = (CNT_W+1)'(FULL_LVL - 1);

	entry_t bank_l [0:BD-1];
	entry_t bank_r [0:BD-1];

	wave_t  w_q;
	logic   act_q;
	entry_t rd_l_q;
	entry_t rd_r_q;
	logic   hit_q;
	logic   hsel_q;

	logic          prb_hit;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	logic          sw_vld;
	logic          sw_sel;
	entry_t        sw_ent;
	logic          mw_en;
	logic          mw_bank;
	logic [AW-1:0] mw_addr;
	entry_t        mw_ent;

	logic             sel;
	entry_t           node;
	logic [CNT_W:0]   hl;
	logic [CNT_W:0]   ci;
	logic [CNT_W+1:0] gl;
	logic             has_l;
	logic             has_r;
	logic             c_r;
	entry_t           child;
	logic             move;
	logic             leaf;

	assign prb_hit = prb.vld && (prb.lvl == LVL_W'(LVL));
	assign rd_en = wave_in.vld || prb_hit;
	assign rd_addr = wave_in.vld ? wave_in.off[AW-1:0] : AW'(prb.off >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			act_q <= wave_in.vld;
			hit_q <= prb_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (wave_in.vld) begin
			w_q <= wave_in;
		end
		if (prb_hit) begin
			hsel_q <= prb.off[0];
		end
		if (rd_en) begin
			rd_l_q <= bank_l[rd_addr];
			rd_r_q <= bank_r[rd_addr];
		end
	end

	assign prb_ent = !hit_q ? '0 : (hsel_q ? rd_r_q : rd_l_q);

	// child selection and heap index arithmetic
	always_comb begin
		sel = w_q.path[CNT_W-1];
		node = sel ? rd_r_q : rd_l_q;
		hl = BASE + (CNT_W+1)'({w_q.off, 1'b0});
		has_l = hl < (CNT_W+1)'(w_q.size);
		has_r = (hl + (CNT_W+1)'(1)) < (CNT_W+1)'(w_q.size);
		c_r = has_r && (rd_r_q.key < rd_l_q.key);
		child = c_r ? rd_r_q : rd_l_q;
		ci = hl + (CNT_W+1)'(c_r);
		gl = {ci, 1'b0} + (CNT_W+2)'(1);
		leaf = gl >= (CNT_W+2)'(w_q.size);
		move = has_l && (child.key < w_q.ent.key);
	end

	always_comb begin
		sw_vld = 1'b0;
		sw_sel = 1'b0;
		sw_ent = w_q.ent;
		wave_out = '0;
		wr_out = '0;
		done = 1'b0;
		if (act_q) begin
			unique case (w_q.op)
				W_ADD: begin
					sw_sel = sel;
					if (w_q.tgt == LVL_W'(LVL)) begin
						sw_vld = 1'b1;
						done = 1'b1;
					end else begin
						wave_out = w_q;
						wave_out.off = OFF_W'({w_q.off, sel});
						wave_out.path = w_q.path << 1;
						if (w_q.disp || (node.key > w_q.ent.key)) begin
							sw_vld = 1'b1;
							wave_out.ent = node;
							wave_out.disp = 1'b1;
						end
					end
				end
				W_SIFT: begin
					wr_out.vld = 1'b1;
					wr_out.off = w_q.off;
					if (!move) begin
						wr_out.ent = w_q.ent;
						done = 1'b1;
					end else begin
						wr_out.ent = child;
						if (leaf) begin
							sw_vld = 1'b1;
							sw_sel = c_r;
							done = 1'b1;
						end else begin
							wave_out = w_q;
							wave_out.off = OFF_W'({w_q.off, c_r});
						end
					end
				end
				default: ;
			endcase
		end
	end

	// one write port shared by own moves and writes from the level below
	always_comb begin
		mw_en = sw_vld || wr_in.vld;
		if (sw_vld) begin
			mw_bank = sw_sel;
			mw_addr = w_q.off[AW-1:0];
			mw_ent = sw_ent;
		end else begin
			mw_bank = wr_in.off[0];
			mw_addr = AW'(wr_in.off >> 1);
			mw_ent = wr_in.ent;
		end
	end

	always_ff @(posedge clk) begin
		if (mw_en) begin
			if (mw_bank) begin
				bank_r[mw_addr] <= mw_ent;
			end else begin
				bank_l[mw_addr] <= mw_ent;
			end
		end
	end

endmodule

// ===== hw/rtl/timer_min_heap_top.sv =====
// timer_min_heap_top: binary min-heap timer queue with add, pop and tick commands
// root register and control here, one tmh_cell per lower heap level
// depends on tmh_pkg and tmh_cell
//
// A command is taken when start is high and busy is low; every result appears on
// result for one cycle with strobe high and cannot be held off. Add, pop and a
// tick that finds nothing give one result; a tick gives one result per expired
// timer, last marking the final one. The heap is the root register and a chain of
// cells, one per lower level, each with its own pair-organized memory, and an
// operation walks it one level per cycle: a cell reads its pair at the edge the
// operation arrives, then compares, writes and hands the operation to the next
// level in the cycle after. An add or removal shows its result once the operation
// stops at its last level, through S_EMIT and the registered strobe. Add to an
// empty heap and the empty, full and nothing-due answers skip the level walk; a
// pop of the only entry goes from S_POP_TAKE straight to S_EMIT.
module timer_min_heap_top import tmh_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic strobe,
	output out_t result
);

	localparam int NL = $clog2(DEPTH + 1);
	localparam int NC = NL - 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	entry_t          root_q, root_d;
	entry_t          taken_q, taken_d;
	logic [KEY_W-1:0] now_q, now_d;
	logic            is_add_q, is_add_d;
	logic            is_tick_q, is_tick_d;
	out_t            res_q, res_d;
	logic            strobe_q, strobe_d;

	wave_t  wv [0:NC];
	wave_t  wv_head;
	wr_t    wb [1:NC+1];
	entry_t pe [1:NC];
	logic [NC:1] dn;
	prb_t   prb;
	entry_t prb_word;

	entry_t           new_e;
	logic [CNT_W-1:0] m_add;
	logic [LVL_W-1:0] lvl_add;
	logic [CNT_W-1:0] m_pop;
	logic [LVL_W-1:0] lvl_pop;
	logic             fin;

	function automatic logic [LVL_W-1:0] msb_pos(input logic [CNT_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

	function automatic out_t mk_res(input status_t s, input entry_t e,
		input logic [OCC_W-1:0] occ, input logic l);
		out_t r;
		r.status = s;
		r.out_id = e.id;
		r.out_expire = e.key;
		r.occupancy = occ;
		r.last = l;
		return r;
	endfunction

	genvar g;
	generate
		for (g = 1; g <= NC; g++) begin : gen_lvl
			tmh_cell #(
				.LVL(g),
				.DEPTH(DEPTH)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.wave_in(wv[g-1]),
				.wave_out(wv[g]),
				.wr_in(wb[g+1]),
				.wr_out(wb[g]),
				.prb(prb),
				.prb_ent(pe[g]),
				.done(dn[g])
			);
		end
	endgenerate

	assign wb[NC+1] = '0;
	assign wv[0] = wv_head;

	always_comb begin
		prb_word = '0;
		for (int i = 1; i <= NC; i++) begin
			prb_word = prb_word | pe[i];
		end
	end

	assign new_e.key = item.expire_time;
	assign new_e.id = item.timer_id;
	assign m_add = CNT_W'(cnt_q) + CNT_W'(1);
	assign lvl_add = msb_pos(m_add);
	assign m_pop = CNT_W'(cnt_q);
	assign lvl_pop = msb_pos(m_pop);
	assign fin = !is_tick_q || (cnt_q == '0) || (root_q.key > now_q);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		root_d = root_q;
		taken_d = taken_q;
		now_d = now_q;
		is_add_d = is_add_q;
		is_tick_d = is_tick_q;
		res_d = res_q;
		strobe_d = 1'b0;
		wv_head = '0;
		prb = '0;
		if (wb[1].vld) begin
			root_d = wb[1].ent;
		end
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					now_d = item.now_time;
					is_add_d = (item.command == CMD_ADD);
					is_tick_d = (item.command == CMD_TICK);
					unique case (item.command)
						CMD_ADD: begin
							if (cnt_q == CW'(DEPTH)) begin
								res_d = mk_res(ST_FULL, '0, OCC_W'(cnt_q), 1'b1);
								strobe_d = 1'b1;
							end else if (cnt_q == '0) begin
								root_d = new_e;
								cnt_d = CW'(1);
								res_d = mk_res(ST_ADDED, '0, OCC_W'(1), 1'b1);
								strobe_d = 1'b1;
							end else begin
								cnt_d = cnt_q + CW'(1);
								wv_head.vld = 1'b1;
								wv_head.op = W_ADD;
								wv_head.tgt = lvl_add;
								wv_head.path = m_add << (LVL_W'(CNT_W) - lvl_add);
								if (root_q.key > new_e.key) begin
									root_d = new_e;
									wv_head.ent = root_q;
									wv_head.disp = 1'b1;
								end else begin
									wv_head.ent = new_e;
								end
								state_d = S_RUN;
							end
						end
						CMD_POP: begin
							if (cnt_q == '0) begin
								res_d = mk_res(ST_EMPTY, '0, OCC_W'(cnt_q), 1'b1);
								strobe_d = 1'b1;
							end else begin
								state_d = S_POP_TAKE;
							end
						end
						CMD_TICK: begin
							if (cnt_q == '0) begin
								res_d = mk_res(ST_EMPTY, '0, OCC_W'(cnt_q), 1'b1);
								strobe_d = 1'b1;
							end else if (root_q.key > item.now_time) begin
								res_d = mk_res(ST_NONE_DUE, '0, OCC_W'(cnt_q), 1'b1);
								strobe_d = 1'b1;
							end else begin
								state_d = S_POP_TAKE;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP_TAKE: begin
				taken_d = root_q;
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					state_d = S_EMIT;
				end else begin
					// fetch the last entry, heap index cnt - 1
					prb.vld = 1'b1;
					prb.lvl = lvl_pop;
					prb.off = OFF_W'(m_pop & ~(CNT_W'(1) << lvl_pop));
					state_d = S_POP_LOAD;
				end
			end
			S_POP_LOAD: begin
				wv_head.vld = 1'b1;
				wv_head.op = W_SIFT;
				wv_head.size = CNT_W'(cnt_q);
				wv_head.ent = prb_word;
				state_d = S_RUN;
			end
			S_RUN: begin
				if (|dn) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				strobe_d = 1'b1;
				if (is_add_q) begin
					res_d = mk_res(ST_ADDED, '0, OCC_W'(cnt_q), 1'b1);
					state_d = S_IDLE;
				end else begin
					res_d = mk_res(ST_REMOVED, taken_q, OCC_W'(cnt_q), fin);
					state_d = fin ? S_IDLE : S_POP_TAKE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		root_q <= root_d;
		taken_q <= taken_d;
		now_q <= now_d;
		is_add_q <= is_add_d;
		is_tick_q <= is_tick_d;
		res_q <= res_d;
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

endmodule

// ===== bench/heap_checker.sv =====
`timescale 1ns / 1ps
// heap_checker: predicts and checks every result transfer of timer_min_heap_top
// keeps its own copy of the heap and compares results in order; depends on tmh_pkg
module heap_checker import tmh_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_t  item,
	input  logic strobe,
	input  out_t result,
	output int   mismatches,
	output int   outstanding,
	output int   heap_fill
);

	entry_t timers [DEPTH];
	int     timer_count;
	out_t   timer_events [$];
	int     err_total = 0;

	task automatic report_mismatch(input string msg);
		err_total++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	function automatic void queue_event(status_t st, logic [ID_W-1:0] id,
			logic [KEY_W-1:0] key, logic fin);
		out_t ev;
		ev.status = st;
		ev.out_id = id;
		ev.out_expire = key;
		ev.occupancy = OCC_W'(timer_count);
		ev.last = fin;
		timer_events.push_back(ev);
	endfunction

	// ties keep the left child and stop the descent
	function automatic void settle_root();
		entry_t moving;
		int pos;
		int c;
		pos = 0;
		if (timer_count < 2)
			return;
		moving = timers[0];
		while (2 * pos + 1 < timer_count) begin
			c = 2 * pos + 1;
			if (c + 1 < timer_count && timers[c + 1].key < timers[c].key)
				c++;
			if (timers[c].key < moving.key) begin
				timers[pos] = timers[c];
				pos = c;
			end else begin
				break;
			end
		end
		timers[pos] = moving;
	endfunction

	function automatic entry_t take_earliest();
		entry_t head;
		head = timers[0];
		timer_count--;
		timers[0] = timers[timer_count];
		settle_root();
		return head;
	endfunction

	function automatic void place_timer(entry_t ent);
		int pos;
		int par;
		pos = timer_count;
		timer_count++;
		while (pos > 0) begin
			par = (pos - 1) / 2;
			if (timers[par].key <= ent.key)
				break;
			timers[pos] = timers[par];
			pos = par;
		end
		timers[pos] = ent;
	endfunction

	function automatic void predict_command(in_t it);
		entry_t ent;
		case (it.command)
			CMD_ADD: begin
				if (timer_count >= DEPTH) begin
					queue_event(ST_FULL, '0, '0, 1'b1);
				end else begin
					ent.key = it.expire_time;
					ent.id = it.timer_id;
					place_timer(ent);
					queue_event(ST_ADDED, '0, '0, 1'b1);
				end
			end
			CMD_POP: begin
				if (timer_count == 0) begin
					queue_event(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					ent = take_earliest();
					queue_event(ST_REMOVED, ent.id, ent.key, 1'b1);
				end
			end
			CMD_TICK: begin
				if (timer_count == 0) begin
					queue_event(ST_EMPTY, '0, '0, 1'b1);
				end else if (timers[0].key > it.now_time) begin
					queue_event(ST_NONE_DUE, '0, '0, 1'b1);
				end else begin
					while (timer_count > 0 && timers[0].key <= it.now_time) begin
						ent = take_earliest();
						queue_event(ST_REMOVED, ent.id, ent.key,
							timer_count == 0 || timers[0].key > it.now_time);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic check_result(input out_t got);
		out_t want;
		if (timer_events.size() == 0) begin
			report_mismatch($sformatf("result %0h with nothing expected", got));
			return;
		end
		want = timer_events.pop_front();
		check_field("status", 64'(got.status), 64'(want.status));
		check_field("out_id", 64'(got.out_id), 64'(want.out_id));
		check_field("out_expire", 64'(got.out_expire), 64'(want.out_expire));
		check_field("occupancy", 64'(got.occupancy), 64'(want.occupancy));
		check_field("last", 64'(got.last), 64'(want.last));
	endtask

	// a result never belongs to the command taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_count = 0;
			timer_events.delete();
			outstanding <= 0;
			heap_fill <= 0;
			mismatches <= err_total;
		end else begin
			if (strobe)
				check_result(result);
			if (start && !busy)
				predict_command(item);
			outstanding <= timer_events.size();
			heap_fill <= timer_count;
			mismatches <= err_total;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: drives add, tick, pop and unused commands into timer_min_heap_top and gives the verdict
// depends on tmh_pkg, heap_checker and timer_min_heap_top
module tb_top import tmh_pkg::*; ();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int N_ITEMS = 460;
	localparam int WINDOW = 256;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic strobe;
	in_t  item;
	out_t result;
	int   mismatches;
	int   outstanding;
	int   heap_fill;
	int   sent = 0;

	always #4 clk = ~clk;

	timer_min_heap_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	heap_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.heap_fill(heap_fill)
	);

	function automatic in_t timer_cmd(logic [1:0] cmd, logic [ID_W-1:0] id,
			logic [KEY_W-1:0] key, logic [KEY_W-1:0] now);
		in_t it;
		it.command = cmd;
		it.timer_id = id;
		it.expire_time = key;
		it.now_time = now;
		return it;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return '0;
		if (sel < 16)
			return '1;
		if (sel < 36)
			return $urandom();
		return $urandom_range(WINDOW - 1);
	endfunction

	function automatic logic [KEY_W-1:0] pick_now();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return '0;
		if (sel < 12)
			return '1;
		if (sel < 22)
			return $urandom();
		return $urandom_range(WINDOW - 1);
	endfunction

	// no idling over a long stretch in the middle of the run
	task automatic send_item(input in_t it);
		int gap;
		gap = 0;
		if ((sent < 200 || sent >= 300) && $urandom_range(99) < 24)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		if (it.command != CMD_UNUSED)
			sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_add(input logic [KEY_W-1:0] key);
		send_item(timer_cmd(CMD_ADD, ID_W'($urandom()), key, $urandom()));
	endtask

	task automatic send_tick(input logic [KEY_W-1:0] now);
		send_item(timer_cmd(CMD_TICK, ID_W'($urandom()), $urandom(), now));
	endtask

	task automatic send_pop();
		send_item(timer_cmd(CMD_POP, ID_W'($urandom()), $urandom(), $urandom()));
	endtask

	// sender holds off until every result is in, then fills past capacity
	task automatic fill_heap();
		int n;
		wait_drained();
		n = DEPTH_DEF - heap_fill + $urandom_range(1, 3);
		repeat (n) send_add(pick_key());
	endtask

	initial begin
		int kind;
		int r;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty heap, ignored command, extremes of ids and keys, ties
		send_pop();
		send_tick('0);
		send_item(timer_cmd(CMD_UNUSED, '1, '1, '1));
		send_item(timer_cmd(CMD_ADD, '0, '1, '0));
		send_tick(32'hFFFF_FFFE);
		send_item(timer_cmd(CMD_ADD, '1, '0, '1));
		send_item(timer_cmd(CMD_ADD, 16'h1234, '0, 32'h5555_5555));
		send_add(32'd100);
		send_add(32'd100);
		send_add(32'd50);
		send_add(32'd7);
		send_tick('0);
		send_tick(32'd99);
		send_item(timer_cmd(CMD_UNUSED, ID_W'($urandom()), $urandom(), $urandom()));
		send_pop();
		send_add(32'hAAAA_AAAA);
		send_add(32'h5555_5555);
		send_tick('1);
		send_pop();
		send_tick('1);

		// full heap, dropped adds, then one tick expiring everything
		fill_heap();
		send_tick('1);

		while (sent < N_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				repeat ($urandom_range(10, 30)) begin
					r = $urandom_range(99);
					if (r < 55)
						send_add(pick_key());
					else if (r < 72)
						send_tick(pick_now());
					else if (r < 95)
						send_pop();
					else
						send_item(timer_cmd(CMD_UNUSED, ID_W'($urandom()), $urandom(),
							$urandom()));
				end
			end else if (kind < 52) begin
				fill_heap();
				if ($urandom_range(1))
					send_tick(pick_now());
			end else if (kind < 64) begin
				repeat ($urandom_range(6, 16)) send_add($urandom_range(3));
				send_tick($urandom_range(3));
			end else if (kind < 74) begin
				repeat ($urandom_range(4, 20)) send_pop();
			end else if (kind < 86) begin
				send_tick(pick_now());
			end else begin
				repeat ($urandom_range(3, 8))
					send_item(timer_cmd(2'($urandom_range(3)), ID_W'($urandom()),
						$urandom(), $urandom()));
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
